[hw/rtl/cra_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the binomial table for the composition rank/unrank block.
// Used by every module of the block; depends on nothing else.

package cra_pkg;

    localparam int COUNT_FIELDS   = 6;
    localparam int MAX_POINTS_DEF = 6;
    localparam int MAX_CHEQUERS   = 15;

    localparam int CNT_W      = 4;
    localparam int ID_W       = 16;
    localparam int PTS_W      = 3;
    localparam int POS_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int TDATA_W    = ID_W + COUNT_FIELDS * CNT_W;

    // Largest chequer total the block honors.
    localparam logic [CNT_W-1:0] CHEQ_LIMIT =
        CNT_W'((MAX_CHEQUERS < (1 << CNT_W) - 1) ? MAX_CHEQUERS : (1 << CNT_W) - 1);

    // Highest bit position a one can take in the stars-and-bars string.
    localparam int LAST_POS = int'(CHEQ_LIMIT) + COUNT_FIELDS - 1;

    localparam int BINOM_ROWS = 1 << POS_W;
    localparam int BINOM_COLS = COUNT_FIELDS + 1;
    localparam int BINOM_W    = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_POINTS   = 1'b0,
        REG_NUM_CHEQUERS = 1'b1
    } cfg_reg_t;

    typedef logic [BINOM_W-1:0]        binom_t;
    typedef binom_t [BINOM_COLS-1:0]   binom_row_t;
    typedef binom_row_t [BINOM_ROWS-1:0] binom_tbl_t;

    // Pascal's triangle, evaluated at elaboration.
    function automatic binom_tbl_t build_binom();
        binom_tbl_t t;
        t = '0;
        for (int n = 0; n < BINOM_ROWS; n++) begin
            for (int k = 0; k < BINOM_COLS; k++) begin
                if (k == 0) begin
                    t[n][k] = binom_t'(1);
                end else if (n > 0) begin
                    t[n][k] = t[n-1][k-1] + t[n-1][k];
                end
            end
        end
        return t;
    endfunction

    localparam binom_tbl_t BINOM = build_binom();

    // One item as it travels down the chain of cells. The gap slot k holds the
    // number of zeros just below the one that has k ones remaining below it.
    typedef struct packed {
        logic                             unrank;
        logic                             err;
        logic [PTS_W-1:0]                 pts;
        logic [POS_W-1:0]                 pos;
        logic [ID_W-1:0]                  acc;
        logic [COUNT_FIELDS:0][CNT_W-1:0] gap;
    } cra_item_t;

endpackage

[hw/rtl/cra_front.sv]
`timescale 1ns / 1ps
// Input stage: configuration registers, range check and setup of the item
// that enters the chain of cells. Depends on cra_pkg.

module cra_front
    import cra_pkg::*;
#(
    parameter int NUM_CELLS = COUNT_FIELDS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_action,
    input  logic [TDATA_W-1:0]    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cra_item_t             out_item
);

    localparam logic [PTS_W-1:0] PTS_MAX = PTS_W'(NUM_CELLS);
    localparam int SUM_W = CNT_W + PTS_W;

    logic [PTS_W-1:0] points_reg, points_next;
    logic [CNT_W-1:0] cheq_reg, cheq_next;
    logic             valid_reg;
    cra_item_t        item_reg, item_next;

    logic [COUNT_FIELDS-1:0][CNT_W-1:0] cnt;
    logic [ID_W-1:0]  id;
    logic [SUM_W-1:0] sum;
    logic [POS_W-1:0] len;
    binom_t           id_limit;

    always_comb begin
        points_next = points_reg;
        cheq_next   = cheq_reg;
        if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_wr_idx))
                REG_NUM_POINTS: begin
                    if (cfg_wr_data[PTS_W-1:0] == '0) begin
                        points_next = PTS_W'(1);
                    end else if (cfg_wr_data[PTS_W-1:0] > PTS_MAX) begin
                        points_next = PTS_MAX;
                    end else begin
                        points_next = cfg_wr_data[PTS_W-1:0];
                    end
                end
                REG_NUM_CHEQUERS: begin
                    cheq_next = (cfg_wr_data[CNT_W-1:0] > CHEQ_LIMIT) ?
                                CHEQ_LIMIT : cfg_wr_data[CNT_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < COUNT_FIELDS; i++) begin
            cnt[i] = in_data[i*CNT_W +: CNT_W];
        end
        id = in_data[COUNT_FIELDS*CNT_W +: ID_W];

        sum = '0;
        for (int i = 0; i < COUNT_FIELDS; i++) begin
            if (i < int'(points_reg)) begin
                sum = sum + SUM_W'(cnt[i]);
            end
        end
        len      = POS_W'(cheq_reg) + POS_W'(points_reg);
        id_limit = BINOM[len][points_reg];

        item_next        = '0;
        item_next.unrank = in_action;
        item_next.pts    = points_reg;
        if (in_action) begin
            item_next.err = (BINOM_W'(id) >= id_limit);
            item_next.pos = len;
            item_next.acc = id;
        end else begin
            item_next.err = (sum > SUM_W'(cheq_reg));
            // One above the top one, so the first cell lands on it with a zero gap.
            item_next.pos = POS_W'(sum + SUM_W'(points_reg));
            for (int k = 0; k < COUNT_FIELDS; k++) begin
                for (int i = 0; i < COUNT_FIELDS; i++) begin
                    if (i + k + 1 == int'(points_reg)) begin
                        item_next.gap[k] = cnt[i];
                    end
                end
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_reg <= PTS_MAX;
            cheq_reg   <= CHEQ_LIMIT;
            valid_reg  <= 1'b0;
        end else begin
            points_reg <= points_next;
            cheq_reg   <= cheq_next;
            if (in_ready) begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

[hw/rtl/cra_cell.sv]
`timescale 1ns / 1ps
// One cell of the chain: places the one that has CELL_K ones left to place,
// either from a given gap (rank) or by a greedy search (unrank). Depends on cra_pkg.

module cra_cell
    import cra_pkg::*;
#(
    parameter int CELL_K = 1
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  cra_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output cra_item_t out_item
);

    logic             valid_reg;
    cra_item_t        item_reg, item_next;
    logic             active;
    logic [POS_W-1:0] lo_pos;
    binom_t           lo_val;
    logic [POS_W-1:0] rank_pos;

    assign active = (PTS_W'(CELL_K) <= in_item.pts);

    always_comb begin
        // The table column is increasing, so the last hit is the largest position.
        lo_pos = POS_W'(CELL_K - 1);
        lo_val = '0;
        for (int b = CELL_K; b <= LAST_POS; b++) begin
            if (BINOM[b][CELL_K] <= BINOM_W'(in_item.acc)) begin
                lo_pos = POS_W'(b);
                lo_val = BINOM[b][CELL_K];
            end
        end
        rank_pos = in_item.pos - POS_W'(in_item.gap[CELL_K]) - POS_W'(1);

        item_next = in_item;
        if (active) begin
            if (in_item.unrank) begin
                item_next.pos         = lo_pos;
                item_next.acc         = in_item.acc - lo_val[ID_W-1:0];
                item_next.gap[CELL_K] = CNT_W'(in_item.pos - lo_pos - POS_W'(1));
            end else begin
                item_next.pos = rank_pos;
                item_next.acc = in_item.acc + BINOM[rank_pos][CELL_K][ID_W-1:0];
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

[hw/rtl/cra_out.sv]
`timescale 1ns / 1ps
// Output stage: turns the item leaving the chain into the result transfer and
// holds it in the output register. Depends on cra_pkg.

module cra_out
    import cra_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  cra_item_t          in_item,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser
);

    logic                             valid_reg;
    logic [TDATA_W-1:0]               tdata_reg, tdata_next;
    logic                             tuser_reg, tuser_next;
    logic [COUNT_FIELDS:0][CNT_W-1:0] gaps;

    always_comb begin
        // The run below the lowest one ends at the string's bottom bit.
        gaps    = in_item.gap;
        gaps[0] = CNT_W'(in_item.pos);

        tdata_next = '0;
        tuser_next = 1'b0;
        if (in_item.err) begin
            tuser_next = 1'b1;
        end else if (!in_item.unrank) begin
            tdata_next[ID_W-1:0] = in_item.acc;
        end else begin
            for (int i = 0; i < COUNT_FIELDS; i++) begin
                for (int k = 0; k < COUNT_FIELDS; k++) begin
                    if (i + k + 1 == int'(in_item.pts)) begin
                        tdata_next[ID_W + i*CNT_W +: CNT_W] = gaps[k];
                    end
                end
            end
        end
    end

    assign in_ready = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            tdata_reg <= tdata_next;
            tuser_reg <= tuser_next;
        end
    end

endmodule

[hw/rtl/composition_rank_unrank.sv]
`timescale 1ns / 1ps
// Ranks chequer counts over up to six points to an index in the combinatorial
// number system, or unranks an index back to counts, one transfer per clock.
// The block takes a new transfer in every cycle while results flow out. A
// result passes through the input register, one registered cell per point
// in the chain, and the output register. Every stage holds its own item, so
// a stalled output only stops the input once all stages are full. Rank mode
// returns the index in the low bits of m_tdata, and unrank mode returns the
// counts above it. m_tuser carries the error flag, and an error result has
// all of m_tdata zero. Write num_points and num_chequers only while no
// transfer is in flight. Depends on cra_pkg and the cra_* modules.

module composition_rank_unrank
    import cra_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // From bit 0: in_count_0 .. in_count_5 (4 bits each), id_in (16 bits).
    input  logic [TDATA_W-1:0]    s_tdata,
    // action: 0 rank, 1 unrank.
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // From bit 0: id_out (16 bits), out_count_0 .. out_count_5 (4 bits each).
    output logic [TDATA_W-1:0]    m_tdata,
    // error.
    output logic                  m_tuser
);

    localparam int NUM_CELLS = (MAX_POINTS < COUNT_FIELDS) ? MAX_POINTS : COUNT_FIELDS;

    cra_item_t stage_item  [NUM_CELLS+1];
    logic      stage_valid [NUM_CELLS+1];
    logic      stage_ready [NUM_CELLS+1];

    cra_front #(
        .NUM_CELLS (NUM_CELLS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tuser),
        .in_data     (s_tdata),
        .out_valid   (stage_valid[0]),
        .out_ready   (stage_ready[0]),
        .out_item    (stage_item[0])
    );

    // The top one is placed first, so the cell count runs down the chain.
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        cra_cell #(
            .CELL_K (NUM_CELLS - g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_item   (stage_item[g]),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_item  (stage_item[g+1])
        );
    end

    cra_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (stage_valid[NUM_CELLS]),
        .in_ready (stage_ready[NUM_CELLS]),
        .in_item  (stage_item[NUM_CELLS]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[hw/rtl/cra_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for composition_rank_unrank, attached by the bind below.
// Depends on cra_pkg.

module cra_checker
    import cra_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tuser
);

    // Reset empties every stage.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // With the output register empty, no stage can be blocking the input.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output is empty");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error result carries data");

    // A result is either an index or a set of counts, never both.
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[ID_W-1:0] != '0) |-> m_tdata[TDATA_W-1:ID_W] == '0)
        else $error("index and counts both nonzero");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind composition_rank_unrank cra_checker u_cra_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[bench/composition_rank_unrank_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for composition_rank_unrank: random and directed rank and unrank
// transfers over many point and chequer settings, checked against a local predictor.
// Depends on cra_pkg and the composition_rank_unrank RTL.

module composition_rank_unrank_test;
    import cra_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 100;
    localparam int PHASE_COUNT  = 12;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic                             unrank;
        logic [COUNT_FIELDS-1:0][CNT_W-1:0] cnt;
        logic [ID_W-1:0]                  id;
    } chq_item_t;

    typedef struct packed {
        logic [ID_W-1:0]                  id;
        logic [COUNT_FIELDS-1:0][CNT_W-1:0] cnt;
        logic                             err;
    } chq_result_t;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata     = '0;
    logic                  s_tuser     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;

    composition_rank_unrank u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_idx (cfg_wr_idx),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // Local copy of the two registers, as last written.
    logic [2:0] cfg_points   = 3'd6;
    logic [3:0] cfg_chequers = 4'd15;

    chq_item_t   pending_items[$];
    chq_result_t expected_results[$];
    chq_item_t   item_on_bus;
    chq_result_t got, want;
    int unsigned send_gap   = 0;
    int unsigned recv_stall = 0;
    int unsigned fail_count = 0;
    int unsigned cycles     = 0;
    bit          idle_on    = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int unsigned choose(int unsigned n, int unsigned k);
        int unsigned res;
        res = 1;
        if (k > n) return 0;
        for (int unsigned t = 1; t <= k; t++) res = res * (n - k + t) / t;
        return res;
    endfunction

    function automatic int unsigned points_in_use();
        int unsigned p;
        p = cfg_points;
        if (p < 1) p = 1;
        if (p > COUNT_FIELDS) p = COUNT_FIELDS;
        return p;
    endfunction

    function automatic chq_result_t predict_composition(chq_item_t it);
        chq_result_t r;
        int unsigned pts, cap, total, top, acc, rank, span, pos, left, bits, idv, c, j;
        int unsigned tally[COUNT_FIELDS];
        r   = '0;
        pts = points_in_use();
        cap = cfg_chequers;
        if (!it.unrank) begin
            total = 0;
            for (int unsigned i = 0; i < pts; i++) total += it.cnt[i];
            if (total > cap) begin
                r.err = 1'b1;
                return r;
            end
            top  = pts - 1 + total;
            rank = choose(top, pts);
            acc  = 0;
            for (int unsigned i = 0; i + 1 < pts; i++) begin
                acc  += it.cnt[i] + 1;
                rank += choose(top - acc, pts - 1 - i);
            end
            r.id = rank[ID_W-1:0];
        end else begin
            idv  = it.id;
            span = cap + pts;
            if (idv >= choose(span, pts)) begin
                r.err = 1'b1;
                return r;
            end
            // Greedy walk from the top position down rebuilds the bit string.
            bits = 0;
            pos  = span;
            left = pts;
            while (left > 0) begin
                if (pos == left) begin
                    bits |= (1 << pos) - 1;
                    break;
                end
                c = choose(pos - 1, left);
                if (idv >= c) begin
                    bits |= 1 << (pos - 1);
                    idv  -= c;
                    left--;
                end
                pos--;
            end
            for (int unsigned i = 0; i < COUNT_FIELDS; i++) tally[i] = 0;
            j = pts - 1;
            for (int unsigned i = 0; i < span; i++) begin
                if (bits[i]) begin
                    if (j == 0) break;
                    j--;
                end else begin
                    tally[j]++;
                end
            end
            for (int unsigned i = 0; i < pts; i++) r.cnt[i] = tally[i][CNT_W-1:0];
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly legal items: rank counts within the chequer limit, indices below the total.
    function automatic chq_item_t make_item();
        chq_item_t   it;
        int unsigned pts, left, take;
        pts       = points_in_use();
        it.unrank = 1'($urandom_range(0, 1));
        it.id     = ID_W'($urandom());
        for (int i = 0; i < COUNT_FIELDS; i++) it.cnt[i] = CNT_W'($urandom());
        if (!it.unrank && $urandom_range(0, 4) != 0) begin
            left = $urandom_range(0, cfg_chequers);
            for (int unsigned i = 0; i < pts; i++) begin
                take = (i == pts - 1 && $urandom_range(0, 1)) ? left : $urandom_range(0, left);
                it.cnt[i] = CNT_W'(take);
                left -= take;
            end
        end else if (it.unrank && $urandom_range(0, 4) != 0) begin
            it.id = ID_W'($urandom_range(0, choose(cfg_chequers + pts, pts) - 1));
        end
        return it;
    endfunction

    task automatic push_item(logic unrank, logic [23:0] counts, logic [ID_W-1:0] id);
        chq_item_t it;
        it.unrank = unrank;
        it.cnt    = counts;
        it.id     = id;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_idx  <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_NUM_POINTS) cfg_points = value[2:0];
        else cfg_chequers = value;
    endtask

    // Driver: loads the next pending item once the current one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) expected_results.push_back(predict_composition(item_on_bus));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    item_on_bus = pending_items.pop_front();
                    s_tdata  <= {item_on_bus.id, item_on_bus.cnt};
                    s_tuser  <= item_on_bus.unrank;
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random backpressure and a field-by-field check of each transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.id  = m_tdata[ID_W-1:0];
                got.cnt = m_tdata[TDATA_W-1:ID_W];
                got.err = m_tuser;
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected: tdata %h tuser %b",
                           m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.err !== want.err) begin
                        $error("error: expected %0d, actual %0d", want.err, got.err);
                        fail_count++;
                    end
                    if (got.id !== want.id) begin
                        $error("id_out: expected %0d, actual %0d", want.id, got.id);
                        fail_count++;
                    end
                    for (int i = 0; i < COUNT_FIELDS; i++) begin
                        if (got.cnt[i] !== want.cnt[i]) begin
                            $error("out_count_%0d: expected %0d, actual %0d",
                                   i, want.cnt[i], got.cnt[i]);
                            fail_count++;
                        end
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_stall = pick_gap();
            end
        end
    end

    initial begin
        logic [3:0] pts_code, cheq_code;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed items at the reset setting: six points, fifteen chequers.
        push_item(1'b0, 24'h000000, 16'h0000);
        push_item(1'b0, 24'h00000F, 16'hFFFF);
        push_item(1'b0, 24'hF00000, 16'h0000);
        push_item(1'b0, 24'h033333, 16'h0000);
        push_item(1'b0, 24'h133333, 16'h0000);
        push_item(1'b0, 24'hFFFFFF, 16'h0000);
        push_item(1'b0, 24'h111111, 16'hFFFF);
        push_item(1'b0, 24'h0000F0, 16'h0000);
        push_item(1'b1, 24'h000000, 16'd0);
        push_item(1'b1, 24'hFFFFFF, 16'd1);
        push_item(1'b1, 24'h000000, 16'd54263);
        push_item(1'b1, 24'h000000, 16'd54264);
        push_item(1'b1, 24'h000000, 16'hFFFF);
        push_item(1'b1, 24'h000000, 16'hAAAA);
        push_item(1'b1, 24'h000000, 16'h5555);
        wait_drained();

        // Smallest setting: one point, no chequers; counts past the first point are ignored.
        write_reg(REG_NUM_POINTS, 4'd1);
        write_reg(REG_NUM_CHEQUERS, 4'd0);
        push_item(1'b0, 24'h000000, 16'h0000);
        push_item(1'b0, 24'hFFFFF0, 16'h0000);
        push_item(1'b0, 24'h000001, 16'h0000);
        push_item(1'b1, 24'h000000, 16'd0);
        push_item(1'b1, 24'h000000, 16'd1);
        wait_drained();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0:       {pts_code, cheq_code} = {4'd1, 4'd15};
                1:       {pts_code, cheq_code} = {4'd6, 4'd0};
                2:       {pts_code, cheq_code} = {4'd8, 4'd9};   // zero points acts as one
                3:       {pts_code, cheq_code} = {4'd7, 4'd15};  // above the limit acts as six
                4:       {pts_code, cheq_code} = {4'd15, 4'd12}; // top data bit is dropped
                5:       {pts_code, cheq_code} = {4'd3, 4'd5};
                6:       {pts_code, cheq_code} = {4'd6, 4'd15};
                default: {pts_code, cheq_code} = {4'($urandom()), 4'($urandom())};
            endcase
            write_reg(REG_NUM_POINTS, pts_code);
            write_reg(REG_NUM_CHEQUERS, cheq_code);
            idle_on = (phase % 3 != 1);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Halfway through some phases the sender holds off until all results are in.
                if (i == PHASE_ITEMS / 2 && phase % 2 == 0) wait_drained();
                @(negedge aclk);
                pending_items.push_back(make_item());
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
